>>> rtl/bbs_pkg.sv
// Shared constants, types and state encoding for the Blum Blum Shub word generator.
// Used by the channel interfaces, the serial modular squarer and the top level.
package bbs_pkg;

    localparam int unsigned RES_W     = 63;   // residue width
    localparam int unsigned WORD_W    = 64;   // output word width
    localparam int unsigned ROUNDS    = 16;   // squarings per word
    localparam int unsigned SHIFT     = 4;    // word shift per squaring
    localparam int unsigned BIT_CNT_W = 6;    // counts the RES_W multiplier bits
    localparam int unsigned ROUND_W   = 4;    // counts the ROUNDS squarings

    localparam logic [31:0] PRIME_P = 32'd2479637879;
    localparam logic [31:0] PRIME_Q = 32'd2479662359;

    // M = P * Q, below 2^63.
    localparam logic [RES_W-1:0] MODULUS = RES_W'(64'(PRIME_P) * 64'(PRIME_Q));

    localparam logic KIND_GEN  = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sq_status;

endpackage

>>> rtl/bbs_req_if.sv
// Request channel: valid/ready handshake carrying the item kind and a seed.
// Depends on bbs_pkg for the residue width.
interface bbs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [bbs_pkg::RES_W-1:0]   seed_value;

    modport source (output valid, output kind, output seed_value, input ready);
    modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

>>> rtl/bbs_rsp_if.sv
// Response channel: valid/ready handshake carrying the random word and final residue.
// Depends on bbs_pkg for the word and residue widths.
interface bbs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bbs_pkg::WORD_W-1:0]  random_word;
    logic [bbs_pkg::RES_W-1:0]   final_residue;

    modport source (output valid, output random_word, output final_residue, input ready);
    modport sink   (input valid, input random_word, input final_residue, output ready);
endinterface

>>> rtl/bbs_sqmod.sv
// Bit-serial modular squarer: x*x mod M by double-and-add, one multiplier bit per cycle.
// Depends on bbs_pkg for widths, the modulus and the status struct.
module bbs_sqmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bbs_pkg::RES_W-1:0]   i_operand,
    output bbs_pkg::t_sq_status         o_status,
    output logic [bbs_pkg::RES_W-1:0]   o_result
);

    localparam int unsigned SUM_W = bbs_pkg::RES_W + 2;

    logic [bbs_pkg::RES_W-1:0]     r_a;
    logic [bbs_pkg::RES_W-1:0]     r_b;
    logic [bbs_pkg::RES_W-1:0]     r_acc;
    logic [bbs_pkg::RES_W-1:0]     n_acc;
    logic [bbs_pkg::BIT_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_m1;
    logic [SUM_W-1:0] w_m2;
    logic [SUM_W-1:0] w_red;

    // Accumulator stays below M, so 2*acc + a stays below 3M and one of
    // three candidates is the reduced value.
    always_comb begin
        w_m1  = {2'b00, bbs_pkg::MODULUS};
        w_m2  = {1'b0, bbs_pkg::MODULUS, 1'b0};
        w_sum = {1'b0, r_acc, 1'b0} + (r_b[bbs_pkg::RES_W-1] ? {2'b00, r_a} : '0);
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        n_acc = w_red[bbs_pkg::RES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bbs_pkg::BIT_CNT_W'(bbs_pkg::RES_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The multiplier copy shifts out most significant bit first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_operand;
            r_b   <= i_operand;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[bbs_pkg::RES_W-2:0], 1'b0};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("squarer started while busy");

    a_done_after_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> (r_done && !r_busy))
        else $error("squarer did not finish after the last bit");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < bbs_pkg::MODULUS))
        else $error("squarer result not reduced below the modulus");

endmodule

>>> rtl/bbs_random_word_generator.sv
// Blum Blum Shub generator top level. A generate transaction runs 16 squarings, each a
// launch, the bit-serial steps in bbs_sqmod and a capture, then loads the output register
// once it is free; a new generate is taken only after the previous one has left ST_DONE.
// A load transaction is absorbed without leaving ST_IDLE, so loads are taken back to back.
// While a result waits in the output register a new transaction may be accepted and run.
// Synchronous active-low reset sets the residue to 3 and empties the output register.
module bbs_random_word_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bbs_req_if.sink       i_req,
    bbs_rsp_if.source     o_rsp
);

    bbs_pkg::t_state                r_state;
    bbs_pkg::t_state                n_state;
    logic [bbs_pkg::ROUND_W-1:0]    r_round;
    logic [bbs_pkg::RES_W-1:0]      r_x;
    logic [bbs_pkg::WORD_W-1:0]     r_word;
    logic                           r_out_valid;
    logic [bbs_pkg::WORD_W-1:0]     r_out_word;
    logic [bbs_pkg::RES_W-1:0]      r_out_res;

    logic                           w_req_ready;
    logic                           w_req_fire;
    logic                           w_start;
    logic                           w_out_load;
    logic                           w_capture;
    logic [bbs_pkg::RES_W-1:0]      w_seed_red;
    logic [bbs_pkg::RES_W-1:0]      w_sq_result;
    bbs_pkg::t_sq_status            w_sq_status;

    bbs_sqmod u_sqmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_operand (r_x),
        .o_status  (w_sq_status),
        .o_result  (w_sq_result)
    );

    assign w_req_fire = i_req.valid && w_req_ready;
    assign w_capture  = (r_state == bbs_pkg::ST_WAIT) && w_sq_status.done;

    // Any 63-bit seed is below 2M, so one conditional subtract reduces it.
    assign w_seed_red = (i_req.seed_value >= bbs_pkg::MODULUS) ?
                        (i_req.seed_value - bbs_pkg::MODULUS) : i_req.seed_value;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbs_pkg::ST_IDLE: begin
                if (w_req_fire && i_req.kind == bbs_pkg::KIND_GEN) begin
                    n_state = bbs_pkg::ST_LAUNCH;
                end
            end
            bbs_pkg::ST_LAUNCH: begin
                n_state = bbs_pkg::ST_WAIT;
            end
            bbs_pkg::ST_WAIT: begin
                if (w_sq_status.done) begin
                    if (r_round == bbs_pkg::ROUND_W'(bbs_pkg::ROUNDS - 1)) begin
                        n_state = bbs_pkg::ST_DONE;
                    end else begin
                        n_state = bbs_pkg::ST_LAUNCH;
                    end
                end
            end
            bbs_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = bbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_req_ready = 1'b0;
        w_start     = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            bbs_pkg::ST_IDLE:   w_req_ready = 1'b1;
            bbs_pkg::ST_LAUNCH: w_start     = 1'b1;
            bbs_pkg::ST_WAIT:   w_start     = 1'b0;
            bbs_pkg::ST_DONE:   w_out_load  = !r_out_valid || o_rsp.ready;
            default:            w_req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbs_pkg::ST_IDLE;
            r_round     <= '0;
            r_x         <= bbs_pkg::RES_W'(3);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_req_fire && i_req.kind == bbs_pkg::KIND_LOAD) begin
                r_x <= w_seed_red;
            end else if (w_capture) begin
                r_x <= w_sq_result;
            end
            if (w_capture) begin
                r_round <= r_round + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sixteen four-bit shifts clear the whole word, so it needs no initial value.
    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_word <= {r_word[bbs_pkg::WORD_W-bbs_pkg::SHIFT-1:0], bbs_pkg::SHIFT'(0)}
                      ^ bbs_pkg::WORD_W'(w_sq_result);
        end
        if (w_out_load) begin
            r_out_word <= r_word;
            r_out_res  <= r_x;
        end
    end

    assign i_req.ready         = w_req_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.random_word   = r_out_word;
    assign o_rsp.final_residue = r_out_res;

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_status.done |-> (r_state == bbs_pkg::ST_WAIT))
        else $error("squarer finished outside the wait state");

    a_launch_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbs_pkg::ST_LAUNCH) |-> !w_sq_status.busy)
        else $error("squaring launched while the squarer is busy");

    a_rounds_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbs_pkg::ST_DONE) |-> (r_round == '0))
        else $error("word finished with a partial round count");

    a_residue_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x < bbs_pkg::MODULUS)
        else $error("residue not below the modulus");

endmodule
